### design/gravity_removed_linear_accel_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gravity removed linear acceleration unit
// Shared concurrent assertion wrappers, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef GRAVITY_REMOVED_LINEAR_ACCEL_UNIT_MACROS_SVH
`define GRAVITY_REMOVED_LINEAR_ACCEL_UNIT_MACROS_SVH

// Checked only while out of reset
`define GRA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked at every edge, reset included
`define GRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/gra_pkg.sv
// ----------------------------------------------------------------------------
// gra_pkg
// Types, widths, register codes and reset values of the linear accel unit.
// ----------------------------------------------------------------------------
package gra_pkg;

  localparam int unsigned ACCEL_FRAC_BITS = 16;

  localparam int unsigned ACC_W  = 32;
  localparam int unsigned QUAT_W = 32;
  localparam int unsigned DT_W   = 25;
  localparam int unsigned TAU_W  = 25;
  localparam int unsigned GRAV_W = 22;
  localparam int unsigned DB_W   = 22;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned CFG_W  = 32;

  // Register indexes
  localparam logic [1:0] CFG_TAU  = 2'd0;
  localparam logic [1:0] CFG_GRAV = 2'd1;
  localparam logic [1:0] CFG_DB   = 2'd2;
  localparam logic [1:0] CFG_CONV = 2'd3;

  // Reset values: tau 0.3 s, g 9.81, deadband 0.2, limit 3000
  localparam logic [TAU_W-1:0] TAU_RESET =
    TAU_W'((64'd3 * (64'd1 << 24) + 64'd5) / 64'd10);
  localparam logic [GRAV_W-1:0] GRAV_RESET =
    GRAV_W'((64'd981 << ACCEL_FRAC_BITS) / 64'd100);
  localparam logic [DB_W-1:0] DB_RESET =
    DB_W'((64'd2 << ACCEL_FRAC_BITS) / 64'd10);
  localparam logic [CNT_W-1:0] CONV_RESET = CNT_W'(3000);

  typedef struct packed {
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  accel_y;
    logic signed [ACC_W-1:0]  accel_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic [DT_W-1:0]          delta_time;
  } accel_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] lin_accel_x;
    logic signed [ACC_W-1:0] lin_accel_y;
    logic signed [ACC_W-1:0] lin_accel_z;
    logic                    converged;
  } accel_out_t;

  // Queue entry: sample plus the flag decided at acceptance
  typedef struct packed {
    accel_in_t smp;
    logic      conv;
  } job_t;

  typedef struct packed {
    logic [TAU_W-1:0]  tau;
    logic [GRAV_W-1:0] grav;
    logic [DB_W-1:0]   db;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic deliver;
  } bk_stat_t;

  // Saturate a 40-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sh0080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### design/gra_fifo.sv
// ----------------------------------------------------------------------------
// gra_fifo
// Two-entry queue between the sample front end and the compute back end.
// ----------------------------------------------------------------------------
module gra_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gra_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output gra_pkg::job_t head_o
);
  import gra_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rp_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

endmodule

### design/gra_front.sv
// ----------------------------------------------------------------------------
// gra_front
// Accepts samples, keeps the sample count and tags each with converged.
// ----------------------------------------------------------------------------
module gra_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  gra_pkg::accel_in_t           in_data_i,
  input  logic [gra_pkg::CNT_W-1:0]    conv_limit_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output gra_pkg::job_t                q_data_o
);
  import gra_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             conv;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign conv       = (cnt_q > conv_limit_i);

  assign q_data_o.smp  = in_data_i;
  assign q_data_o.conv = conv;

  // count until converged, saturating at all ones
  always_comb begin
    cnt_d = cnt_q;
    if (q_push_o && !conv && (cnt_q != {CNT_W{1'b1}})) cnt_d = cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

### design/gra_back.sv
// ----------------------------------------------------------------------------
// gra_back
// Sequenced datapath: rotation matrix, gravity removal, low-pass filter
// with a bit-serial divider, rotation back, deadband and output register.
// ----------------------------------------------------------------------------
module gra_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gra_pkg::cfg_t       cfg_i,
  input  logic                q_valid_i,
  input  gra_pkg::job_t       q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gra_pkg::accel_out_t out_data_o,
  output gra_pkg::bk_stat_t   stat_o
);
  import gra_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_QP   = 4'd1;
  localparam logic [3:0] S_MAT  = 4'd2;
  localparam logic [3:0] S_GRAV = 4'd3;
  localparam logic [3:0] S_DIFF = 4'd4;
  localparam logic [3:0] S_FILT = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_DWB  = 4'd7;
  localparam logic [3:0] S_ROT  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam int unsigned NUM_W = 60;
  localparam int unsigned DEN_W = TAU_W + 1;
  localparam logic [5:0]  DIV_LAST = 6'(NUM_W - 1);

  logic [3:0] st_q;
  logic       wb_q;
  logic [3:0] k_q;
  logic [1:0] r_q, c_q;
  logic [5:0] dcnt_q;
  logic       ovalid_q;

  accel_in_t                smp_q;
  logic                     conv_q;
  logic signed [33:0]       p_q [9];
  logic signed [31:0]       m_q [9];
  logic signed [31:0]       gb_q [3];
  logic signed [31:0]       f_q [3];
  logic signed [31:0]       earth_q [3];
  logic signed [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]         dvd_q;
  logic [DEN_W-1:0]         rem_q;
  logic                     neg_q;
  logic signed [39:0]       acc_q;
  logic signed [67:0]       prod_q;
  accel_out_t               out_q;

  // -------- operand selection --------
  logic [DEN_W-1:0]   den;
  logic [3:0]         msel;
  logic [1:0]         fsel;
  logic signed [31:0] m_rd, f_rd, acc_r;
  logic signed [32:0] diff;
  logic signed [33:0] opa, opb;
  logic signed [67:0] psh_full;
  logic signed [39:0] psh;

  assign den  = {1'b0, cfg_i.tau} + {1'b0, smp_q.delta_time};
  assign msel = (st_q == S_GRAV) ? (4'd6 + {2'b00, r_q})
                                 : ({1'b0, r_q, 1'b0} + {2'b00, r_q} + {2'b00, c_q});
  assign fsel = (st_q == S_ROT) ? c_q : r_q;
  assign m_rd = m_q[msel];
  assign f_rd = f_q[fsel];

  always_comb begin
    case (r_q)
      2'd0:    acc_r = smp_q.accel_x;
      2'd1:    acc_r = smp_q.accel_y;
      default: acc_r = smp_q.accel_z;
    endcase
  end

  assign diff = 33'(acc_r) - 33'(gb_q[r_q]);

  always_comb begin
    opa = '0;
    opb = '0;
    case (st_q)
      S_QP: begin
        case (k_q)
          4'd0:    begin opa = 34'(smp_q.quat_x); opb = 34'(smp_q.quat_x); end
          4'd1:    begin opa = 34'(smp_q.quat_y); opb = 34'(smp_q.quat_y); end
          4'd2:    begin opa = 34'(smp_q.quat_z); opb = 34'(smp_q.quat_z); end
          4'd3:    begin opa = 34'(smp_q.quat_x); opb = 34'(smp_q.quat_y); end
          4'd4:    begin opa = 34'(smp_q.quat_x); opb = 34'(smp_q.quat_z); end
          4'd5:    begin opa = 34'(smp_q.quat_y); opb = 34'(smp_q.quat_z); end
          4'd6:    begin opa = 34'(smp_q.quat_w); opb = 34'(smp_q.quat_x); end
          4'd7:    begin opa = 34'(smp_q.quat_w); opb = 34'(smp_q.quat_y); end
          default: begin opa = 34'(smp_q.quat_w); opb = 34'(smp_q.quat_z); end
        endcase
      end
      S_GRAV: begin
        opa = 34'(m_rd);
        opb = $signed({12'd0, cfg_i.grav});
      end
      S_DIFF: begin
        opa = 34'(diff);
        opb = $signed({9'd0, smp_q.delta_time});
      end
      S_FILT: begin
        opa = 34'(f_rd);
        opb = $signed({9'd0, cfg_i.tau});
      end
      S_ROT: begin
        opa = 34'(m_rd);
        opb = 34'(f_rd);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign psh_full = prod_q >>> 30;
  assign psh      = psh_full[39:0];

  // -------- rotation matrix from the quaternion products --------
  localparam logic signed [39:0] Q30_ONE = 40'sd1 <<< 30;
  logic signed [39:0] pe [9];
  logic signed [31:0] m_d [9];

  always_comb begin
    for (int i = 0; i < 9; i++) pe[i] = 40'(p_q[i]);
    // products: xx yy zz xy xz yz wx wy wz
    m_d[0] = sat32(Q30_ONE - ((pe[1] + pe[2]) <<< 1));
    m_d[1] = sat32((pe[3] - pe[8]) <<< 1);
    m_d[2] = sat32((pe[4] + pe[7]) <<< 1);
    m_d[3] = sat32((pe[3] + pe[8]) <<< 1);
    m_d[4] = sat32(Q30_ONE - ((pe[0] + pe[2]) <<< 1));
    m_d[5] = sat32((pe[5] - pe[6]) <<< 1);
    m_d[6] = sat32((pe[4] - pe[7]) <<< 1);
    m_d[7] = sat32((pe[5] + pe[6]) <<< 1);
    m_d[8] = sat32(Q30_ONE - ((pe[0] + pe[1]) <<< 1));
  end

  // -------- filter numerator, divider step, quotient saturation --------
  logic signed [NUM_W-1:0] num_sum, num_mag;
  logic [DEN_W:0]          rem_sh;
  logic                    qbit;
  logic [DEN_W:0]          rem_diff;
  logic signed [31:0]      quo_sat;
  logic signed [39:0]      rot_sum;

  assign num_sum  = num_q + prod_q[NUM_W-1:0];
  assign num_mag  = num_sum[NUM_W-1] ? -num_sum : num_sum;
  assign rem_sh   = {rem_q, dvd_q[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, den};
  assign qbit     = (rem_sh >= {1'b0, den});
  assign rot_sum  = ((c_q == 2'd0) ? 40'sd0 : acc_q) + psh;

  always_comb begin
    if (!neg_q) begin
      quo_sat = (|dvd_q[NUM_W-1:31]) ? 32'sh7FFFFFFF : $signed(dvd_q[31:0]);
    end else if ((|dvd_q[NUM_W-1:32]) || (dvd_q[31] && (|dvd_q[30:0]))) begin
      quo_sat = 32'sh80000000;
    end else begin
      quo_sat = -$signed(dvd_q[31:0]);
    end
  end

  // -------- deadband and handshake --------
  logic        load;
  logic [32:0] mag_e [3];
  logic signed [31:0] lin [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_e[i] = earth_q[i][31] ? (33'd0 - 33'(earth_q[i])) : 33'(earth_q[i]);
      lin[i]   = (mag_e[i] < {11'd0, cfg_i.db}) ? 32'sd0 : earth_q[i];
    end
  end

  assign load    = (st_q == S_OUT) && (!ovalid_q || out_ready_i);
  assign q_pop_o = (st_q == S_IDLE) && q_valid_i;

  assign stat_o.idle    = (st_q == S_IDLE);
  assign stat_o.deliver = load;

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  // -------- sequencer and filter state --------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      wb_q     <= 1'b0;
      k_q      <= '0;
      r_q      <= '0;
      c_q      <= '0;
      dcnt_q   <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 3; i++) f_q[i] <= '0;
    end else begin
      if (load)             ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;

      case (st_q)
        S_IDLE: begin
          if (q_valid_i) begin
            st_q <= S_QP;
            k_q  <= '0;
            wb_q <= 1'b0;
          end
        end
        S_QP: begin
          wb_q <= !wb_q;
          if (wb_q) begin
            if (k_q == 4'd8) st_q <= S_MAT;
            else             k_q  <= k_q + 4'd1;
          end
        end
        S_MAT: begin
          st_q <= S_GRAV;
          r_q  <= '0;
        end
        S_GRAV: begin
          wb_q <= !wb_q;
          if (wb_q) begin
            if (r_q == 2'd2) begin
              st_q <= S_DIFF;
              r_q  <= '0;
            end else begin
              r_q <= r_q + 2'd1;
            end
          end
        end
        S_DIFF: begin
          wb_q <= !wb_q;
          if (wb_q) st_q <= S_FILT;
        end
        S_FILT: begin
          wb_q <= !wb_q;
          if (wb_q) begin
            if (den != '0) begin
              st_q   <= S_DIV;
              dcnt_q <= '0;
            end else if (r_q == 2'd2) begin
              st_q <= S_ROT;
              r_q  <= '0;
              c_q  <= '0;
            end else begin
              st_q <= S_DIFF;
              r_q  <= r_q + 2'd1;
            end
          end
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == DIV_LAST) st_q <= S_DWB;
        end
        S_DWB: begin
          f_q[r_q] <= quo_sat;
          if (r_q == 2'd2) begin
            st_q <= S_ROT;
            r_q  <= '0;
            c_q  <= '0;
          end else begin
            st_q <= S_DIFF;
            r_q  <= r_q + 2'd1;
          end
        end
        S_ROT: begin
          wb_q <= !wb_q;
          if (wb_q) begin
            if (c_q == 2'd2) begin
              c_q <= '0;
              if (r_q == 2'd2) st_q <= S_OUT;
              else             r_q  <= r_q + 2'd1;
            end else begin
              c_q <= c_q + 2'd1;
            end
          end
        end
        S_OUT: begin
          if (load) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // -------- datapath registers --------
  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    if (q_pop_o) begin
      smp_q  <= q_head_i.smp;
      conv_q <= q_head_i.conv;
    end
    if (st_q == S_QP && wb_q)   p_q[k_q]  <= psh[33:0];
    if (st_q == S_MAT) begin
      for (int i = 0; i < 9; i++) m_q[i] <= m_d[i];
    end
    if (st_q == S_GRAV && wb_q) gb_q[r_q] <= sat32(psh);
    if (st_q == S_DIFF && wb_q) num_q     <= prod_q[NUM_W-1:0];
    if (st_q == S_FILT && wb_q) begin
      dvd_q <= num_mag + NUM_W'(den >> 1);
      rem_q <= '0;
      neg_q <= num_sum[NUM_W-1];
    end
    if (st_q == S_DIV) begin
      rem_q <= qbit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      dvd_q <= {dvd_q[NUM_W-2:0], qbit};
    end
    if (st_q == S_ROT && wb_q) begin
      acc_q <= rot_sum;
      if (c_q == 2'd2) earth_q[r_q] <= sat32(rot_sum);
    end
    if (load) begin
      out_q.lin_accel_x <= lin[0];
      out_q.lin_accel_y <= lin[1];
      out_q.lin_accel_z <= lin[2];
      out_q.converged   <= conv_q;
    end
  end

endmodule

### design/gravity_removed_linear_accel_unit.sv
// ----------------------------------------------------------------------------
// gravity_removed_linear_accel_unit
// Gravity-compensated, low-pass filtered earth-frame linear acceleration.
// ----------------------------------------------------------------------------
//  channel | signals                              | transaction
//  in      | in_valid_i  in_ready_o  in_data_i    | one IMU sample
//  out     | out_valid_o out_ready_i out_data_o   | one result
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i  | one register write
//          | cfg_data_i                           |
//
// The back end's time per sample is set by the bit-serial divider (run once
// per axis, three axes) and by the shared 34x34 multiplier. A zero tau+dt
// skips the division.
// The front end takes samples into a two-entry queue while the back end works.
// Reset restores the registers, clears the filter state and the sample count.
// Config writes are always ready.
module gravity_removed_linear_accel_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  gra_pkg::accel_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gra_pkg::accel_out_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [gra_pkg::CFG_W-1:0]     cfg_data_i
);
  import gra_pkg::*;

  `include "gravity_removed_linear_accel_unit_macros.svh"

  cfg_t             cfg_q;
  logic [CNT_W-1:0] conv_limit_q;

  logic     fq_push, fq_full, fq_pop, fq_valid;
  job_t     fq_in, fq_head;
  bk_stat_t bk_stat;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tau    <= TAU_RESET;
      cfg_q.grav   <= GRAV_RESET;
      cfg_q.db     <= DB_RESET;
      conv_limit_q <= CONV_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TAU:  cfg_q.tau    <= cfg_data_i[TAU_W-1:0];
        CFG_GRAV: cfg_q.grav   <= cfg_data_i[GRAV_W-1:0];
        CFG_DB:   cfg_q.db     <= cfg_data_i[DB_W-1:0];
        CFG_CONV: conv_limit_q <= cfg_data_i[CNT_W-1:0];
        default:  ;
      endcase
    end
  end

  gra_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .conv_limit_i (conv_limit_q),
    .q_full_i     (fq_full),
    .q_push_o     (fq_push),
    .q_data_o     (fq_in)
  );

  gra_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fq_push),
    .push_data_i (fq_in),
    .full_o      (fq_full),
    .pop_i       (fq_pop),
    .valid_o     (fq_valid),
    .head_o      (fq_head)
  );

  gra_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (fq_valid),
    .q_head_i    (fq_head),
    .q_pop_o     (fq_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (bk_stat)
  );

  // a new result only appears after the back end loaded it
  `GRA_ASSERT(a_out_from_back, clk_i, rst_ni, $rose(out_valid_o) |-> $past(bk_stat.deliver), "result valid without a load")
  // a popped queue entry always starts work
  `GRA_ASSERT(a_pop_starts_work, clk_i, rst_ni, fq_pop |=> !bk_stat.idle, "queue entry popped but back end idle")
  // no result while in reset, checked on the edge after reset is seen
  `GRA_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

### verif/gravity_removed_linear_accel_unit_tb.sv
// ----------------------------------------------------------------------------
// Linear acceleration unit testbench
// Drives IMU samples through the gravity removed linear accel unit. A
// scoreboard predicts each result: gravity rotation, low-pass filter,
// deadband and converged flag. It checks every output transaction in order.
// The run covers several register settings, random stalls and back-pressure.
// ----------------------------------------------------------------------------
module gravity_removed_linear_accel_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gra_pkg::*;

  localparam longint CYCLE_LIMIT = 20000000;
  localparam longint Q30_ONE     = 64'sd1 << 30;
  localparam int     SETTLE      = 300;

  // Predicts results and holds the outstanding ones
  class AccelScoreboard;
    logic [TAU_W-1:0]  tau;
    logic [GRAV_W-1:0] grav;
    logic [DB_W-1:0]   db;
    logic [CNT_W-1:0]  conv_limit;
    longint            filt[3];
    int unsigned       sample_cnt;
    accel_out_t        lin_accel_pending[$];
    int                errors;

    function new();
      tau        = TAU_RESET;
      grav       = GRAV_RESET;
      db         = DB_RESET;
      conv_limit = CONV_RESET;
      filt       = '{0, 0, 0};
      sample_cnt = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_TAU:  tau        = val[TAU_W-1:0];
        CFG_GRAV: grav       = val[GRAV_W-1:0];
        CFG_DB:   db         = val[DB_W-1:0];
        CFG_CONV: conv_limit = val[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Q30 product, floor
    function longint qprod(longint a, longint b);
      return (a * b) >>> 30;
    endfunction

    function void note_sample(accel_in_t s);
      longint     a[3], g[3], gb[3], e[3], m[3][3];
      longint     w, x, y, z, xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint     dt, tv, den, num, mag, q, sum, v;
      accel_out_t r;
      a[0] = longint'($signed(s.accel_x));
      a[1] = longint'($signed(s.accel_y));
      a[2] = longint'($signed(s.accel_z));
      w = longint'($signed(s.quat_w));
      x = longint'($signed(s.quat_x));
      y = longint'($signed(s.quat_y));
      z = longint'($signed(s.quat_z));
      dt  = longint'(s.delta_time);
      tv  = longint'(tau);
      den = tv + dt;
      xx = qprod(x, x); yy = qprod(y, y); zz = qprod(z, z);
      xy = qprod(x, y); xz = qprod(x, z); yz = qprod(y, z);
      wx = qprod(w, x); wy = qprod(w, y); wz = qprod(w, z);
      m[0][0] = clip32(Q30_ONE - 2 * (yy + zz));
      m[0][1] = clip32(2 * (xy - wz));
      m[0][2] = clip32(2 * (xz + wy));
      m[1][0] = clip32(2 * (xy + wz));
      m[1][1] = clip32(Q30_ONE - 2 * (xx + zz));
      m[1][2] = clip32(2 * (yz - wx));
      m[2][0] = clip32(2 * (xz - wy));
      m[2][1] = clip32(2 * (yz + wx));
      m[2][2] = clip32(Q30_ONE - 2 * (xx + yy));
      g = '{0, 0, longint'(grav)};
      // gravity into body frame (transposed matrix)
      for (int i = 0; i < 3; i++) begin
        sum = 0;
        for (int c = 0; c < 3; c++) sum += (m[c][i] * g[c]) >>> 30;
        gb[i] = clip32(sum);
      end
      // low-pass, rounded half away from zero; zero denominator holds state
      if (den != 0) begin
        for (int i = 0; i < 3; i++) begin
          num = (a[i] - gb[i]) * dt + filt[i] * tv;
          mag = (num < 0) ? -num : num;
          q = (mag + den / 2) / den;
          filt[i] = clip32((num < 0) ? -q : q);
        end
      end
      // back to earth frame, then deadband
      for (int i = 0; i < 3; i++) begin
        sum = 0;
        for (int c = 0; c < 3; c++) sum += (m[i][c] * filt[c]) >>> 30;
        v = clip32(sum);
        if (((v < 0) ? -v : v) < longint'(db)) v = 0;
        e[i] = v;
      end
      r.lin_accel_x = e[0][31:0];
      r.lin_accel_y = e[1][31:0];
      r.lin_accel_z = e[2][31:0];
      if (sample_cnt > conv_limit) begin
        r.converged = 1'b1;
      end else begin
        r.converged = 1'b0;
        if (sample_cnt < 65535) sample_cnt++;
      end
      lin_accel_pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(accel_out_t o);
      accel_out_t w;
      if (lin_accel_pending.size() == 0) begin
        report("unexpected result, lin_accel_x", longint'(o.lin_accel_x), 0);
      end else begin
        w = lin_accel_pending.pop_front();
        if (o.lin_accel_x !== w.lin_accel_x)
          report("lin_accel_x", longint'(o.lin_accel_x), longint'(w.lin_accel_x));
        if (o.lin_accel_y !== w.lin_accel_y)
          report("lin_accel_y", longint'(o.lin_accel_y), longint'(w.lin_accel_y));
        if (o.lin_accel_z !== w.lin_accel_z)
          report("lin_accel_z", longint'(o.lin_accel_z), longint'(w.lin_accel_z));
        if (o.converged !== w.converged)
          report("converged", longint'(o.converged), longint'(w.converged));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  accel_in_t         in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  accel_out_t        out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_TAU;
  logic [CFG_W-1:0]  cfg_data = '0;

  AccelScoreboard    sb = new();
  longint            cycle_cnt = 0;
  bit                long_hold_req = 1'b0;
  bit                quiet_sink = 1'b0;
  bit                quiet_source = 1'b0;

  gravity_removed_linear_accel_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Gap length: mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 400);
    return $urandom_range(1, 4);
  endfunction

  // Result sink with random stalls and an occasional long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 3000;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet_sink && $urandom_range(0, 7) == 0) begin
        stall_left = gap_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one sample; valid stays high into the next call when no gap follows
  task automatic send_sample(accel_in_t s);
    int gap;
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
    gap = (quiet_source || $urandom_range(0, 3) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.lin_accel_pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(longint t, longint g, longint d, longint c);
    write_reg(CFG_TAU, CFG_W'(t));
    write_reg(CFG_GRAV, CFG_W'(g));
    write_reg(CFG_DB, CFG_W'(d));
    write_reg(CFG_CONV, CFG_W'(c));
  endtask

  function automatic logic [31:0] rand_quat_part(bit full);
    longint v;
    if (full) v = longint'($urandom_range(0, 32'h8000_0000)) - (64'sd1 << 30);
    else v = longint'($urandom_range(0, 32'h4000_0000)) - (64'sd1 << 29);
    return v[31:0];
  endfunction

  function automatic logic [31:0] rand_accel(bit full);
    longint v;
    if (full) return $urandom;
    v = longint'($urandom_range(0, 60 << 16)) - (64'sd30 << 16);
    return v[31:0];
  endfunction

  function automatic accel_in_t rand_sample();
    accel_in_t s;
    bit        full;
    int        k;
    full = ($urandom_range(0, 9) == 0);
    s.accel_x = rand_accel(full);
    s.accel_y = rand_accel(full);
    s.accel_z = rand_accel(full);
    s.quat_w  = rand_quat_part(full);
    s.quat_x  = rand_quat_part(full);
    s.quat_y  = rand_quat_part(full);
    s.quat_z  = rand_quat_part(full);
    k = $urandom_range(0, 19);
    if (k == 0) s.delta_time = '0;
    else if (k == 1) s.delta_time = DT_W'(1 << 24);
    else if (k < 5) s.delta_time = DT_W'($urandom_range(0, 1 << 24));
    else s.delta_time = DT_W'($urandom_range(8000, 40000));
    return s;
  endfunction

  // Edge cases: field extremes, axis rotations, zero dt
  task automatic run_directed();
    accel_in_t s;
    logic [31:0] qv[5];
    qv = '{32'sd0, 32'sd1073741824, -32'sd1073741824, 32'sd759250125, 32'sd1};
    for (int i = 0; i < 20; i++) begin
      s.accel_x    = (i % 4 == 0) ? 32'h7FFF_FFFF : (i % 4 == 1) ? 32'h8000_0000 :
                     (i % 4 == 2) ? 32'h0 : 32'h0009_CF5C;
      s.accel_y    = (i % 3 == 0) ? 32'h8000_0000 : (i % 3 == 1) ? 32'h7FFF_FFFF : 32'h0;
      s.accel_z    = (i % 2 == 0) ? 32'h0009_CF5C : 32'hFFFF_FFFF;
      s.quat_w     = qv[i % 5];
      s.quat_x     = qv[(i / 5) % 5];
      s.quat_y     = qv[(i + 2) % 5];
      s.quat_z     = qv[(i * 3) % 5];
      s.delta_time = (i % 3 == 0) ? DT_W'(0) : (i % 3 == 1) ? DT_W'(1 << 24) : DT_W'(16777);
      send_sample(s);
    end
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_sample(rand_sample());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings
    run_directed();
    run_random(300);
    wait_drained();

    // All registers at zero: zero tau and gravity, no deadband, early converged
    set_regs(0, 0, 0, 0);
    run_directed();
    run_random(300);
    wait_drained();

    // Large settings, long output hold-off while samples keep coming
    set_regs(64'd1 << 24, 64'd2097152, 64'd2097152, 64'd65534);
    long_hold_req = 1'b1;
    quiet_source = 1'b1;
    run_random(300);
    quiet_source = 1'b0;
    wait_drained();

    // Short tau, no stalls at all
    set_regs(2000, GRAV_RESET, 0, 5);
    quiet_sink = 1'b1;
    quiet_source = 1'b1;
    run_random(300);
    quiet_sink = 1'b0;
    quiet_source = 1'b0;
    wait_drained();

    // Random settings
    for (int p = 0; p < 3; p++) begin
      set_regs($urandom_range(0, 1 << 24), $urandom_range(0, 2097152),
               $urandom_range(0, 1 << 16), $urandom_range(0, 65534));
      run_random(230);
      wait_drained();
    end

    if (sb.errors == 0 && sb.lin_accel_pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/gra_pkg.sv
design/gra_fifo.sv
design/gra_front.sv
design/gra_back.sv
design/gravity_removed_linear_accel_unit.sv
verif/gravity_removed_linear_accel_unit_tb.sv
